@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge, masked while reset is low.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/tdpt_pkg.sv @@
// Shared types for the trial division primality test block.
// No dependencies.
package tdpt_pkg;

    // Control from the sequencer to the remainder unit
    typedef struct packed {
        logic start;
    } div_ctrl_t;

    // Status from the remainder unit back to the sequencer
    typedef struct packed {
        logic done;
        logic rem_zero;
    } rem_stat_t;

endpackage

@@ rtl/core/tdpt_if.sv @@
// Valid/ready channel interfaces for the trial division primality test.
// No dependencies.
interface tdpt_cand_if #(
    parameter int VALUE_BITS = 31
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] candidate;

    modport source (output valid, output candidate, input ready);
    modport sink   (input valid, input candidate, output ready);
endinterface

interface tdpt_res_if;
    logic valid;
    logic ready;
    logic is_prime;

    modport source (output valid, output is_prime, input ready);
    modport sink   (input valid, input is_prime, output ready);
endinterface

@@ rtl/core/tdpt_rem_unit.sv @@
// Bit-serial restoring remainder unit: one quotient bit per cycle.
// Depends on tdpt_pkg for the control and status structs.
module tdpt_rem_unit #(
    parameter int VALUE_BITS = 31
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tdpt_pkg::div_ctrl_t   ctrl,
    input  logic [VALUE_BITS-1:0] dividend,
    input  logic [VALUE_BITS-1:0] divisor,
    output tdpt_pkg::rem_stat_t   stat
);

    localparam int CNT_BITS = $clog2(VALUE_BITS);

    logic                  busy_reg;
    logic                  done_reg;
    logic                  zero_reg;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic [VALUE_BITS-1:0] num_reg;
    logic [VALUE_BITS-1:0] rem_reg;

    logic [VALUE_BITS:0]   trial;
    logic                  trial_ge;
    logic [VALUE_BITS-1:0] rem_next;

    // Shift in the next dividend bit and subtract when it fits
    always_comb
    begin
        trial    = {rem_reg, num_reg[VALUE_BITS-1]};
        trial_ge = (trial >= {1'b0, divisor});
        if (trial_ge)
        begin
            rem_next = VALUE_BITS'(trial - {1'b0, divisor});
        end
        else
        begin
            rem_next = trial[VALUE_BITS-1:0];
        end
    end

    // Sequence control: load on start, count down one bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(VALUE_BITS - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_BITS'(1);
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: partial remainder and dividend shift register
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            num_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[VALUE_BITS-2:0], 1'b0};
            rem_reg <= rem_next;
            if (cnt_reg == '0)
            begin
                zero_reg <= (rem_next == '0);
            end
        end
    end

    assign stat.done     = done_reg;
    assign stat.rem_zero = zero_reg;

endmodule

@@ rtl/core/trial_division_primality_test.sv @@
// Trial division primality test: one candidate in, one is_prime flag out. A candidate
// below two, or even, is settled by the check state without a division. An odd
// candidate is divided by 3, 5, 7, ... on one shared bit-serial remainder unit. The
// divisor square is kept by a running add, so no multiplier is used. cand.ready is
// high only while no item is in work; a finished result waits in the output register
// while the next item is accepted.
// Depends on tdpt_pkg, tdpt_if and tdpt_rem_unit.
module trial_division_primality_test #(
    parameter int VALUE_BITS = 31
) (
    input  logic         clk,
    input  logic         rst_n,
    tdpt_cand_if.sink    cand,
    tdpt_res_if.source   res
);

    localparam int SQ_BITS = VALUE_BITS + 1;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_CHECK  = 2'd1;
    localparam logic [1:0] S_DIV    = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]            state_reg,   state_next;
    logic [VALUE_BITS-1:0] value_reg,   value_next;
    logic [VALUE_BITS-1:0] div_reg,     div_next;
    logic [SQ_BITS-1:0]    sq_reg,      sq_next;
    logic                  prime_reg,   prime_next;
    logic                  out_vld_reg, out_vld_next;
    logic                  out_bit_reg, out_bit_next;

    tdpt_pkg::div_ctrl_t   div_ctrl;
    tdpt_pkg::rem_stat_t   rem_stat;

    // Shared remainder unit
    tdpt_rem_unit #(
        .VALUE_BITS (VALUE_BITS)
    ) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (value_reg),
        .divisor  (div_reg),
        .stat     (rem_stat)
    );

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        value_next     = value_reg;
        div_next       = div_reg;
        sq_next        = sq_reg;
        prime_next     = prime_reg;
        out_vld_next   = out_vld_reg;
        out_bit_next   = out_bit_reg;
        div_ctrl.start = 1'b0;

        // Drop the delivered result
        if (out_vld_reg && res.ready)
        begin
            out_vld_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cand.valid)
                begin
                    value_next = cand.candidate;
                    div_next   = VALUE_BITS'(3);
                    sq_next    = SQ_BITS'(9);
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                priority if (value_reg < VALUE_BITS'(2))
                begin
                    prime_next = 1'b0;
                    state_next = S_FINISH;
                end
                else if (!value_reg[0])
                begin
                    prime_next = (value_reg == VALUE_BITS'(2));
                    state_next = S_FINISH;
                end
                else if ((div_reg >= value_reg) || (sq_reg > {1'b0, value_reg}))
                begin
                    prime_next = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    div_ctrl.start = 1'b1;
                    state_next     = S_DIV;
                end
            end
            S_DIV:
            begin
                if (rem_stat.done)
                begin
                    if (rem_stat.rem_zero)
                    begin
                        prime_next = 1'b0;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        // Advance to the next odd divisor: (d+2)^2 = d^2 + 4d + 4
                        div_next   = div_reg + VALUE_BITS'(2);
                        sq_next    = sq_reg + SQ_BITS'({div_reg, 2'b00}) + SQ_BITS'(4);
                        state_next = S_CHECK;
                    end
                end
            end
            S_FINISH:
            begin
                // Hold until the output register is free
                if (!out_vld_reg || res.ready)
                begin
                    out_vld_next = 1'b1;
                    out_bit_next = prime_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        value_reg   <= value_next;
        div_reg     <= div_next;
        sq_reg      <= sq_next;
        prime_reg   <= prime_next;
        out_bit_reg <= out_bit_next;
    end

    assign cand.ready   = (state_reg == S_IDLE);
    assign res.valid    = out_vld_reg;
    assign res.is_prime = out_bit_reg;

endmodule

@@ rtl/core/tdpt_checker.sv @@
// Port-level checker for the trial division primality test, with its bind.
// Depends on assert_macros.svh and the top level trial_division_primality_test.
`include "assert_macros.svh"

module tdpt_checker (
    input logic clk,
    input logic rst_n,
    input logic cand_valid,
    input logic cand_ready,
    input logic res_valid,
    input logic res_ready,
    input logic is_prime
);

    // A stalled result stays offered
    `ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid, "result dropped while stalled")

    // A stalled result keeps its value
    `ASSERT_NEXT(a_res_stable, res_valid && !res_ready, $stable(is_prime), "stalled result changed")

    // An accepted item closes the input
    `ASSERT_NEXT(a_busy_after_accept, cand_valid && cand_ready, !cand_ready, "ready after accept")

    // No result appears in the cycle right after an accept
    `ASSERT_NEXT(a_no_instant_result, cand_valid && cand_ready, !$rose(res_valid), "result too early")

    // A new result is raised together with the input opening again
    `ASSERT_IMPL(a_rise_when_busy, $rose(res_valid), cand_ready, "result rose while input closed")

endmodule

bind trial_division_primality_test tdpt_checker u_tdpt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cand_valid (cand.valid),
    .cand_ready (cand.ready),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .is_prime   (res.is_prime)
);

@@ bench/trial_division_primality_test_test.sv @@
// Self-checking bench for the trial division primality test: drives candidates over the
// valid/ready channel, predicts each verdict by its own trial division and checks results.
// Depends on tdpt_if (channel interfaces) and trial_division_primality_test.
module trial_division_primality_test_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VALUE_BITS = 31;
    localparam logic [VALUE_BITS-1:0] VALUE_MASK = '1;
    // Random items are kept to at most this many divisors, so the run stays short
    localparam int unsigned MAX_DIVISORS = 200;
    localparam int LONG_HOLD_CYCLES = 2000;
    localparam int TAIL_CYCLES = 4 * (VALUE_BITS + 2);
    localparam int CYCLE_LIMIT = 6_000_000;
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        logic [VALUE_BITS-1:0] value;
        bit                    is_prime;
    } verdict_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  send_valid = 1'b0;
    logic [VALUE_BITS-1:0] send_value = '0;
    logic                  take_ready = 1'b0;

    logic [VALUE_BITS-1:0] cand_backlog [$];
    verdict_t              verdicts_due [$];

    int send_idle_pct = 0;
    int take_idle_pct = 0;
    int hold_tag = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int failures = 0;
    int cycle_count = 0;

    tdpt_cand_if #(.VALUE_BITS(VALUE_BITS)) cand_if ();
    tdpt_res_if res_if ();

    assign cand_if.valid     = send_valid;
    assign cand_if.candidate = send_value;
    assign res_if.ready      = take_ready;

    trial_division_primality_test #(
        .VALUE_BITS (VALUE_BITS)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cand  (cand_if),
        .res   (res_if)
    );

    // Decide primality by odd trial divisors; also report how many divisors were tried
    function automatic bit trial_divide(input logic [VALUE_BITS-1:0] value,
                                        output int unsigned tried);
        longint unsigned v;
        longint unsigned d;
        bit              verdict;
        v = 64'(value);
        tried = 0;
        verdict = 1'b1;
        if (v < 2)
            verdict = 1'b0;
        else if (v[0] == 1'b0)
            verdict = (v == 2);
        else
        begin
            d = 3;
            while (verdict && d < v && d * d <= v)
            begin
                tried++;
                if (v % d == 0)
                    verdict = 1'b0;
                d += 2;
            end
        end
        return verdict;
    endfunction

    task automatic note_failure(input string what);
        if (failures < REPORT_LIMIT)
            $display("[%0t] %s", $realtime, what);
        failures++;
    endtask

    task automatic set_idling(input int send_pct, input int take_pct);
        send_idle_pct = send_pct;
        take_idle_pct = take_pct;
    endtask

    // Wait until every queued item has gone in and every verdict has come back
    task automatic wait_drained();
        while (cand_backlog.size() != 0 || send_valid || verdicts_due.size() != 0)
            @(negedge clk);
    endtask

    always #4 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** trial_division_primality_test: FAILED **");
            $finish;
        end
    end

    // Offer items from the backlog, idling at random between them
    always @(posedge clk or negedge rst_n)
    begin : drive_items
        logic                  next_valid;
        logic [VALUE_BITS-1:0] next_value;
        verdict_t              entry;
        int unsigned           tried;
        if (!rst_n)
        begin
            send_valid <= 1'b0;
            send_value <= '0;
        end
        else
        begin
            next_valid = send_valid;
            next_value = send_value;
            // Record the verdict due for an accepted item
            if (send_valid && cand_if.ready)
            begin
                entry.value = send_value;
                entry.is_prime = trial_divide(send_value, tried);
                verdicts_due.push_back(entry);
                next_valid = 1'b0;
            end
            if (!next_valid && cand_backlog.size() != 0
                && $urandom_range(99) >= send_idle_pct)
            begin
                next_value = cand_backlog.pop_front();
                next_valid = 1'b1;
            end
            send_valid <= next_valid;
            send_value <= next_value;
        end
    end

    // Count down a long receiver hold-off once one is requested
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_seen <= 0;
        end
        else if (hold_seen != hold_tag)
        begin
            hold_left <= LONG_HOLD_CYCLES;
            hold_seen <= hold_tag;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Take results, compare against the oldest verdict due, stall at random
    always @(posedge clk or negedge rst_n)
    begin : take_results
        verdict_t entry;
        if (!rst_n)
            take_ready <= 1'b0;
        else
        begin
            if (res_if.valid && take_ready)
            begin
                if (verdicts_due.size() == 0)
                    note_failure($sformatf("unexpected result is_prime=%0b", res_if.is_prime));
                else
                begin
                    entry = verdicts_due.pop_front();
                    if (res_if.is_prime !== entry.is_prime)
                        note_failure($sformatf("candidate %0d: is_prime expected %0b, got %0b",
                                               entry.value, entry.is_prime, res_if.is_prime));
                end
            end
            take_ready <= (hold_left == 0) && ($urandom_range(99) >= take_idle_pct);
        end
    end

    initial
    begin : stimulus
        logic [VALUE_BITS-1:0] directed [$];
        logic [VALUE_BITS-1:0] value;
        int unsigned           tried;
        int                    pick;
        int                    width;

        // Hold reset, then release it on a rising edge
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: one, two, three, small squares, the extremes and a larger semiprime
        directed = '{31'd1, 31'd2, 31'd3, 31'd4, 31'd5, 31'd6, 31'd8, 31'd9, 31'd15,
                     31'd25, 31'd49, 31'd97, 31'd121, 31'd169, 31'd65537, 31'd1052651,
                     31'd1073741824, 31'd2147483643, 31'd2147483645, 31'd2147483646,
                     31'd2147483647};
        set_idling(36, 60);
        foreach (directed[i])
            cand_backlog.push_back(directed[i]);
        wait_drained();

        // Random: three phases with the idling pattern changing between them
        for (int phase = 0; phase < 3; phase++)
        begin
            if (phase == 1)
                set_idling(60, 36);
            else if (phase == 2)
            begin
                set_idling(0, 0);
                hold_tag++;
            end
            for (int n = 0; n < 34; n++)
            begin
                // Mostly small values, some medium, a few full width with a small factor
                do
                begin
                    pick = $urandom_range(99);
                    if (pick < 60)
                        value = VALUE_BITS'($urandom_range(4095, 1));
                    else if (pick < 85)
                    begin
                        width = $urandom_range(20, 13);
                        value = VALUE_BITS'($urandom() & ((32'd1 << width) - 32'd1));
                    end
                    else
                        value = VALUE_BITS'($urandom()) & VALUE_MASK;
                    void'(trial_divide(value, tried));
                end
                while (value == 0 || tried > MAX_DIVISORS);
                cand_backlog.push_back(value);
            end
            wait_drained();
        end

        // Let any stray result show before judging
        repeat (TAIL_CYCLES) @(negedge clk);
        failures += verdicts_due.size();
        if (failures == 0)
            $display("** trial_division_primality_test: PASSED **");
        else
            $display("** trial_division_primality_test: FAILED **");
        $finish;
    end

endmodule
